[sv/urldec_pkg.sv]
// Shared types, character constants and hex helper for the URL percent decoder.
package urldec_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam int MAX_RESULTS = 3;

  // Up to three result bytes produced by one input item.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [1:0]                  cnt;
    logic                        last;
  } group_t;

  // Bit 4 set when the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

[sv/urldec_step.sv]
// Decode state and the per-item decode logic that builds one result group.
module urldec_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           in_byte,
  input  logic                 in_eos,
  output urldec_pkg::group_t   group
);
  import urldec_pkg::*;

  logic       in_query, in_query_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_digit, held_digit_next;

  logic [4:0] hv, hd;
  logic       is_hex;
  logic [7:0] dec_byte, pl_byte;
  logic       brk_pct, brk_dig, dec_en, plain_en, pl_emit, fl_pct, fl_dig;
  logic [4:0] slot_en;
  logic [4:0][7:0] slot_val;
  logic [2:0] n;

  always_comb begin
    hv = hex_value(in_byte);
    hd = hex_value(held_digit);
    is_hex = !hv[4];
    dec_byte = {hd[3:0], hv[3:0]};
    if (dec_byte < CTRL_LIMIT || dec_byte == CHAR_DEL) begin
      dec_byte = CHAR_UNDER;
    end

    in_query_next = in_query;
    held_count_next = held_count;
    held_digit_next = held_digit;
    brk_pct = 1'b0;
    brk_dig = 1'b0;
    dec_en = 1'b0;
    plain_en = 1'b0;

    case (held_count)
      2'd1: begin
        if (is_hex) begin
          held_count_next = 2'd2;
          held_digit_next = in_byte;
        end else begin
          held_count_next = 2'd0;
          brk_pct = 1'b1;
          plain_en = 1'b1;
        end
      end
      2'd2: begin
        held_count_next = 2'd0;
        if (is_hex) begin
          dec_en = 1'b1;
        end else begin
          brk_pct = 1'b1;
          brk_dig = 1'b1;
          plain_en = 1'b1;
        end
      end
      default: begin
        held_count_next = 2'd0;
        plain_en = 1'b1;
      end
    endcase

    // Plain byte: '?' opens the query, '+' in the query is a space, '%' starts an escape.
    pl_emit = 1'b0;
    pl_byte = in_byte;
    if (plain_en) begin
      if (in_byte == CHAR_QMARK) begin
        in_query_next = 1'b1;
      end
      if (in_byte == CHAR_PLUS && in_query_next) begin
        pl_byte = CHAR_SPACE;
        pl_emit = 1'b1;
      end else if (in_byte == CHAR_PCT) begin
        held_count_next = 2'd1;
      end else begin
        pl_emit = 1'b1;
      end
    end

    fl_pct = 1'b0;
    fl_dig = 1'b0;
    if (in_eos) begin
      fl_pct = held_count_next == 2'd1 || held_count_next == 2'd2;
      fl_dig = held_count_next == 2'd2;
      held_count_next = 2'd0;
      in_query_next = 1'b0;
    end

    slot_en  = {fl_dig, fl_pct, dec_en | pl_emit, brk_dig, brk_pct};
    slot_val = {held_digit_next, CHAR_PCT, (dec_en ? dec_byte : pl_byte), held_digit,
                CHAR_PCT};

    // Pack the enabled slots in order; anything past the third is dropped.
    group = '0;
    n = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (slot_en[i] && n < 3'(MAX_RESULTS)) begin
        group.data[n[1:0]] = slot_val[i];
        n = n + 3'd1;
      end
    end
    group.cnt = n[1:0];
    group.last = in_eos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_query <= 1'b0;
      held_count <= 2'd0;
      held_digit <= 8'd0;
    end else if (take) begin
      in_query <= in_query_next;
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

[sv/urldec_outq.sv]
// Result group register that hands its bytes out one item at a time.
module urldec_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  urldec_pkg::group_t group,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import urldec_pkg::*;

  logic [MAX_RESULTS-1:0][7:0] data;
  logic [1:0] rem;
  logic [1:0] pos;
  logic       grp_last;

  assign out_valid = rem != 2'd0;
  assign out_byte  = data[pos];
  assign out_last  = grp_last && rem == 2'd1;
  // The register can take a new group as its final byte leaves.
  assign free      = rem == 2'd0 || (rem == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      pos <= 2'd0;
    end else if (load) begin
      rem <= group.cnt;
      pos <= 2'd0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= group.data;
      grp_last <= group.last;
    end
  end

endmodule

[sv/url_percent_decoder.sv]
// Top level of the streaming URL percent decoder.
//
//   channel  | dir | tdata (low bit up) | tlast
//   s_axis   | in  | in_byte[7:0]       | end_of_string
//   m_axis   | out | out_byte[7:0]      | last
//
// An accepted item waits in the input register, is decoded into a group of
// zero to three result bytes, and those leave one item per cycle unless
// m_axis stalls. One input item per cycle is sustained while each gives at
// most one result and m_axis is ready; more results hold the input until sent.
// Reset is synchronous and clears the query flag, the held escape and both
// registers' valid state. A stall on m_axis backs up into s_axis tready.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic       m_axis_tlast
);
  import urldec_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       free;
  logic       take;
  group_t     group;

  assign take = in_valid && free;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  urldec_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .in_eos  (in_eos),
    .group   (group)
  );

  urldec_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .group     (group),
    .free      (free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

[tb/tb_url_percent_decoder.sv]
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 100ps

module tb_url_percent_decoder;
  import urldec_pkg::*;

  localparam int         RANDOM_ITEMS  = 335;
  localparam int         CALM_ITEMS    = 40;
  localparam int         LONG_HOLD     = 300;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES  = 16;
  localparam logic [4:0] NOT_HEX       = 5'd16;
  localparam logic [1:0] HELD_NONE     = 2'd0;
  localparam logic [1:0] HELD_PCT      = 2'd1;
  localparam logic [1:0] HELD_DIGIT    = 2'd2;

  typedef struct packed {
    logic [7:0]      data;
    logic            last;
  } result_t;

  // One input item; when fixed is set, the expected results are given in res.
  typedef struct packed {
    logic [7:0]      b;
    logic            eos;
    logic            fixed;
    logic [1:0]      n;
    logic [2:0][7:0] res;
  } url_item_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // in_byte[7:0]
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // out_byte[7:0]
  logic       m_axis_tlast;

  url_item_t  url_bytes[$];
  result_t    decoded_q[$];
  int         errors = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  // Decoder state as seen by the predictor.
  logic       pq_query;
  logic [1:0] pq_held;
  logic [7:0] pq_digit;
  logic [7:0] pred_data[3];
  int         pred_n;

  url_percent_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return 5'(c[3:0] + 4'd9);
    return NOT_HEX;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 1) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (nibble_of(c) != NOT_HEX);
    return c;
  endfunction

  task automatic put(input logic [7:0] b);
    if (pred_n < MAX_RESULTS) begin
      pred_data[pred_n] = b;
      pred_n++;
    end
  endtask

  task automatic plain(input logic [7:0] b);
    if (b == CHAR_QMARK) pq_query = 1'b1;
    if (b == CHAR_PLUS && pq_query) put(CHAR_SPACE);
    else if (b == CHAR_PCT) pq_held = HELD_PCT;
    else put(b);
  endtask

  // Advances the predicted state by one item and leaves its results in pred_data.
  task automatic decode_step(input logic [7:0] b, input logic eos);
    logic [4:0] v;
    logic [4:0] hi;
    logic [7:0] d;
    v = nibble_of(b);
    pred_n = 0;
    if (pq_held == HELD_PCT) begin
      if (v != NOT_HEX) begin
        pq_held  = HELD_DIGIT;
        pq_digit = b;
      end else begin
        pq_held = HELD_NONE;
        put(CHAR_PCT);
        plain(b);
      end
    end else if (pq_held == HELD_DIGIT) begin
      pq_held = HELD_NONE;
      if (v != NOT_HEX) begin
        hi = nibble_of(pq_digit);
        d  = {hi[3:0], v[3:0]};
        if (d < CTRL_LIMIT || d == CHAR_DEL) d = CHAR_UNDER;
        put(d);
      end else begin
        put(CHAR_PCT);
        put(pq_digit);
        plain(b);
      end
    end else begin
      plain(b);
    end
    if (eos) begin
      if (pq_held != HELD_NONE) put(CHAR_PCT);
      if (pq_held == HELD_DIGIT) put(pq_digit);
      pq_held  = HELD_NONE;
      pq_query = 1'b0;
    end
  endtask

  // n < 0 leaves the row to the predictor.
  task automatic add_row(input logic [7:0] b, input logic eos, input int n = -1,
                         input logic [7:0] r0 = 8'h00, input logic [7:0] r1 = 8'h00,
                         input logic [7:0] r2 = 8'h00);
    url_item_t it;
    it.b     = b;
    it.eos   = eos;
    it.fixed = (n >= 0);
    it.n     = (n >= 0) ? 2'(n) : 2'd0;
    it.res   = {r2, r1, r0};
    url_bytes.push_back(it);
  endtask

  // Mostly well-formed URL fragments, with broken escapes and raw bytes mixed in.
  task automatic add_random_string();
    logic [7:0] s[$];
    int         len;
    int         kind;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        s.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (kind < 55) begin
        s.push_back(CHAR_PCT);
        s.push_back(hex_char());
        s.push_back(hex_char());
      end else if (kind < 62) begin
        s.push_back(CHAR_QMARK);
      end else if (kind < 72) begin
        s.push_back(CHAR_PLUS);
      end else if (kind < 80) begin
        s.push_back(CHAR_PCT);
        if ($urandom_range(0, 1) == 1) s.push_back(hex_char());
        s.push_back(non_hex_char());
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Sometimes the string ends in the middle of an escape.
    if ($urandom_range(0, 5) == 0) begin
      s.push_back(CHAR_PCT);
      if ($urandom_range(0, 1) == 1) s.push_back(hex_char());
    end
    foreach (s[i]) add_row(s[i], i == s.size() - 1);
  endtask

  task automatic report_mismatch(input string what, input logic [8:0] want,
                                 input logic [8:0] got);
    errors++;
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
  endtask

  // Receiver: random stalls, plus one long hold-off requested by the sender.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Outputs are sampled mid-cycle; the handshake completes at the next rising edge.
  always @(negedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected item", 9'h000, {m_axis_tlast, m_axis_tdata});
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch("out_byte", {1'b0, want.data}, {1'b0, m_axis_tdata});
        if (m_axis_tlast !== want.last)
          report_mismatch("last", {8'h00, want.last}, {8'h00, m_axis_tlast});
      end
    end
  end

  always @(negedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** url_percent_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    url_item_t it;
    result_t   r;
    int        cnt;
    int        directed_rows;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    pq_query = 1'b0;
    pq_held  = HELD_NONE;
    pq_digit = 8'h00;

    // Extremes of the byte range, plus handling before and after a query mark.
    add_row(8'h00, 1'b0, 1, 8'h00);
    add_row(8'hFF, 1'b1, 1, 8'hFF);
    add_row(CHAR_PLUS, 1'b0, 1, CHAR_PLUS);
    add_row(CHAR_QMARK, 1'b0, 1, CHAR_QMARK);
    add_row(CHAR_PLUS, 1'b0, 1, CHAR_SPACE);
    // A plain escape, then control and DEL values that map to an underscore.
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("4", 1'b0);
    add_row("1", 1'b0);
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("0", 1'b0, 0);
    add_row("a", 1'b0, 1, CHAR_UNDER);
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("7", 1'b0, 0);
    add_row("F", 1'b0, 1, CHAR_UNDER);
    // A decoded plus sign is plain data even inside the query.
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("2", 1'b0);
    add_row("b", 1'b0);
    // Broken escapes with one and two held characters.
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("g", 1'b0, 2, CHAR_PCT, "g");
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("3", 1'b0, 0);
    add_row("z", 1'b0, 3, CHAR_PCT, "3", "z");
    // Held characters are flushed at the end of the string.
    add_row(CHAR_PCT, 1'b0, 0);
    add_row("e", 1'b1, 2, CHAR_PCT, "e");
    add_row(CHAR_PCT, 1'b1, 1, CHAR_PCT);
    directed_rows = url_bytes.size();
    while (url_bytes.size() < directed_rows + RANDOM_ITEMS) add_random_string();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < url_bytes.size(); k++) begin
      it   = url_bytes[k];
      calm = (k >= url_bytes.size() - CALM_ITEMS);
      if (k == directed_rows) hold_req = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.b;
      s_axis_tlast  <= it.eos;
      do @(negedge clk); while (!s_axis_tready);
      @(posedge clk);

      decode_step(it.b, it.eos);
      cnt = it.fixed ? int'(it.n) : pred_n;
      for (int i = 0; i < cnt; i++) begin
        r.data = it.fixed ? it.res[i] : pred_data[i];
        r.last = it.eos && (i == cnt - 1);
        decoded_q.push_back(r);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule

[url_percent_decoder.f]
sv/urldec_pkg.sv
sv/urldec_step.sv
sv/urldec_outq.sv
sv/url_percent_decoder.sv
tb/tb_url_percent_decoder.sv
